### design/msp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_pkg
// Types and constants shared by the master guide table payload parser.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int ENTRY_HDR_BYTES = 11;
    localparam int TOPLEN_BYTES    = 2;
    localparam int HEAD_LAST_INDEX = 2;
    localparam int ENTRY_LEN_INDEX = 10;
    localparam logic [7:0] PID_HI_MASK  = 8'h1f;
    localparam logic [7:0] LEN_HI_MASK  = 8'h0f;

    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = 2;
    localparam int Q_LEVEL_BITS = 3;

    typedef enum logic [2:0] {
        KIND_HEAD  = 3'd0,
        KIND_ENTRY = 3'd1,
        KIND_EDESC = 3'd2,
        KIND_TDESC = 3'd3,
        KIND_DATA  = 3'd4,
        KIND_DONE  = 3'd5,
        KIND_ERR   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_ENTRY,
        PH_TOPLEN,
        PH_TAG,
        PH_LEN,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        first_of_section;
        logic [11:0] payload_length;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  protocol_version;
        logic [15:0] tables_defined;
        logic [15:0] table_type;
        logic [12:0] table_pid;
        logic [4:0]  table_version;
        logic [31:0] number_bytes;
        logic [7:0]  desc_tag;
        logic [7:0]  desc_length;
        logic [7:0]  data_byte;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  rec0;
        t_out_item  rec1;
    } t_push;

    typedef struct packed {
        logic                    valid;
        logic                    room;
        logic [Q_LEVEL_BITS-1:0] level;
    } t_q_status;

endpackage
`default_nettype wire

### design/msp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_front
// Byte parser: walks the section payload and emits up to two records a beat.
// ----------------------------------------------------------------------------
module msp_front #(
    parameter int LENGTH_BITS = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire msp_pkg::t_in_item i_item,
    output msp_pkg::t_push         o_push
);

    localparam int LW = LENGTH_BITS;
    localparam int SW = ((LW > 12) ? LW : 12) + 1;

    msp_pkg::t_phase r_phase, n_phase;
    logic            r_tbl, n_tbl;
    logic [LW-1:0]   r_bp, n_bp;
    logic [LW-1:0]   r_sl, n_sl;
    logic [15:0]     r_tables, n_tables;
    logic [3:0]      r_fbi, n_fbi;
    logic [15:0]     r_type, n_type;
    logic [12:0]     r_pid, n_pid;
    logic [4:0]      r_ver, n_ver;
    logic [31:0]     r_size, n_size;
    logic [LW-1:0]   r_loop_end, n_loop_end;
    logic [7:0]      r_tag, n_tag;
    logic [7:0]      r_dbl, n_dbl;

    function automatic msp_pkg::t_out_item mk_rec(input msp_pkg::t_kind k);
        msp_pkg::t_out_item r;
        r      = '0;
        r.kind = k;
        return r;
    endfunction

    always_comb begin
        msp_pkg::t_out_item recs [2];
        msp_pkg::t_out_item rec;
        logic [1:0]  cnt;
        logic [7:0]  b;
        logic [3:0]  fbi_cur;
        logic        loop_ph;
        logic        do_start, start_tbl, do_finish, do_next;
        logic [11:0] len;
        logic [SW-1:0] end_pos;

        n_phase    = r_phase;
        n_tbl      = r_tbl;
        n_bp       = r_bp;
        n_sl       = r_sl;
        n_tables   = r_tables;
        n_fbi      = r_fbi;
        n_type     = r_type;
        n_pid      = r_pid;
        n_ver      = r_ver;
        n_size     = r_size;
        n_loop_end = r_loop_end;
        n_tag      = r_tag;
        n_dbl      = r_dbl;

        recs[0]   = '0;
        recs[1]   = '0;
        rec       = '0;
        cnt       = 2'd0;
        b         = i_item.payload_byte;
        fbi_cur   = 4'd0;
        loop_ph   = 1'b0;
        do_start  = 1'b0;
        start_tbl = 1'b0;
        do_finish = 1'b0;
        do_next   = 1'b0;
        len       = 12'd0;
        end_pos   = '0;

        if (i_accept) begin
            if (i_item.first_of_section) begin
                n_sl     = LW'(i_item.payload_length);
                n_bp     = '0;
                n_tables = 16'd0;
                n_fbi    = 4'd0;
                n_phase  = msp_pkg::PH_HEAD;
            end
            if (n_phase != msp_pkg::PH_IDLE) begin
                n_bp    = n_bp + LW'(1);
                fbi_cur = n_fbi;
                n_fbi   = fbi_cur + 4'd1;
                case (n_phase)
                    msp_pkg::PH_HEAD: begin
                        if (fbi_cur == 4'd0) begin
                            n_tag = b;
                        end else begin
                            n_tables = {n_tables[7:0], b};
                        end
                        if (fbi_cur >= 4'(msp_pkg::HEAD_LAST_INDEX)) begin
                            rec                  = mk_rec(msp_pkg::KIND_HEAD);
                            rec.protocol_version = n_tag;
                            rec.tables_defined   = n_tables;
                            recs[cnt[0]]         = rec;
                            cnt                  = cnt + 2'd1;
                            do_next              = 1'b1;
                        end else if (n_bp >= n_sl) begin
                            recs[cnt[0]] = mk_rec(msp_pkg::KIND_ERR);
                            cnt          = cnt + 2'd1;
                            n_phase      = msp_pkg::PH_IDLE;
                        end
                    end
                    msp_pkg::PH_ENTRY: begin
                        if (fbi_cur < 4'd2) begin
                            n_type = {r_type[7:0], b};
                        end else if (fbi_cur == 4'd2) begin
                            n_pid = {b[4:0] & msp_pkg::PID_HI_MASK[4:0], 8'h00};
                        end else if (fbi_cur == 4'd3) begin
                            n_pid = {r_pid[12:8], b};
                        end else if (fbi_cur == 4'd4) begin
                            n_ver = b[4:0] & msp_pkg::PID_HI_MASK[4:0];
                        end else if (fbi_cur < 4'd9) begin
                            n_size = {r_size[23:0], b};
                        end else if (fbi_cur == 4'd9) begin
                            n_loop_end = LW'(b & msp_pkg::LEN_HI_MASK);
                        end
                        if (fbi_cur >= 4'(msp_pkg::ENTRY_LEN_INDEX)) begin
                            rec               = mk_rec(msp_pkg::KIND_ENTRY);
                            rec.table_type    = r_type;
                            rec.table_pid     = r_pid;
                            rec.table_version = r_ver;
                            rec.number_bytes  = r_size;
                            recs[cnt[0]]      = rec;
                            cnt               = cnt + 2'd1;
                            len               = {r_loop_end[3:0], b};
                            do_start          = 1'b1;
                            start_tbl         = 1'b0;
                        end
                    end
                    msp_pkg::PH_TOPLEN: begin
                        if (fbi_cur == 4'd0) begin
                            n_loop_end = LW'(b & msp_pkg::LEN_HI_MASK);
                            n_fbi      = 4'd1;
                        end else begin
                            len       = {r_loop_end[3:0], b};
                            do_start  = 1'b1;
                            start_tbl = 1'b1;
                        end
                    end
                    msp_pkg::PH_TAG: begin
                        loop_ph = 1'b1;
                        n_tag   = b;
                        n_phase = msp_pkg::PH_LEN;
                    end
                    msp_pkg::PH_LEN: begin
                        loop_ph = 1'b1;
                        if (SW'(n_bp) + SW'(b) <= SW'(r_loop_end)) begin
                            rec = mk_rec(r_tbl ? msp_pkg::KIND_TDESC
                                               : msp_pkg::KIND_EDESC);
                            rec.desc_tag    = r_tag;
                            rec.desc_length = b;
                            recs[cnt[0]]    = rec;
                            cnt             = cnt + 2'd1;
                            n_dbl           = b;
                            n_phase = (b != 8'd0) ? msp_pkg::PH_DATA : msp_pkg::PH_TAG;
                        end else begin
                            n_phase = msp_pkg::PH_SKIP;
                        end
                    end
                    msp_pkg::PH_DATA: begin
                        loop_ph       = 1'b1;
                        rec           = mk_rec(msp_pkg::KIND_DATA);
                        rec.desc_tag  = r_tag;
                        rec.data_byte = b;
                        recs[cnt[0]]  = rec;
                        cnt           = cnt + 2'd1;
                        n_dbl         = r_dbl - 8'd1;
                        if (n_dbl == 8'd0) begin
                            n_phase = msp_pkg::PH_TAG;
                        end
                    end
                    msp_pkg::PH_SKIP: begin
                        loop_ph = 1'b1;
                    end
                    default: begin
                        n_phase = msp_pkg::PH_IDLE;
                    end
                endcase
                if (loop_ph && (n_bp == n_loop_end)) begin
                    do_finish = 1'b1;
                end
            end
        end

        if (do_start) begin
            end_pos = SW'(n_bp) + SW'(len);
            if (end_pos > SW'(n_sl)) begin
                recs[cnt[0]] = mk_rec(msp_pkg::KIND_ERR);
                cnt          = cnt + 2'd1;
                n_phase      = msp_pkg::PH_IDLE;
            end else begin
                n_loop_end = end_pos[LW-1:0];
                n_phase    = msp_pkg::PH_TAG;
                n_tbl      = start_tbl;
                if (n_bp == n_loop_end) begin
                    do_finish = 1'b1;
                end
            end
        end

        if (do_finish) begin
            if (n_tbl) begin
                recs[cnt[0]] = mk_rec(msp_pkg::KIND_DONE);
                cnt          = cnt + 2'd1;
                n_phase      = msp_pkg::PH_IDLE;
            end else begin
                n_tables = n_tables - 16'd1;
                do_next  = 1'b1;
            end
        end

        if (do_next) begin
            n_fbi = 4'd0;
            if ((n_tables != 16'd0) &&
                (SW'(n_bp) + SW'(msp_pkg::ENTRY_HDR_BYTES) <= SW'(n_sl))) begin
                n_phase = msp_pkg::PH_ENTRY;
            end else if (SW'(n_bp) + SW'(msp_pkg::TOPLEN_BYTES) <= SW'(n_sl)) begin
                n_phase = msp_pkg::PH_TOPLEN;
            end else begin
                recs[cnt[0]] = mk_rec(msp_pkg::KIND_ERR);
                cnt          = cnt + 2'd1;
                n_phase      = msp_pkg::PH_IDLE;
            end
        end

        o_push.count = cnt;
        o_push.rec0  = recs[0];
        o_push.rec1  = recs[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= msp_pkg::PH_IDLE;
            r_tbl    <= 1'b0;
            r_bp     <= '0;
            r_sl     <= '0;
            r_tables <= 16'd0;
            r_fbi    <= 4'd0;
        end else begin
            r_phase  <= n_phase;
            r_tbl    <= n_tbl;
            r_bp     <= n_bp;
            r_sl     <= n_sl;
            r_tables <= n_tables;
            r_fbi    <= n_fbi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_pid      <= n_pid;
        r_ver      <= n_ver;
        r_size     <= n_size;
        r_loop_end <= n_loop_end;
        r_tag      <= n_tag;
        r_dbl      <= n_dbl;
    end

endmodule
`default_nettype wire

### design/msp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_queue
// Four-record queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module msp_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire msp_pkg::t_push         i_push,
    input  wire logic                   i_pop,
    output msp_pkg::t_out_item          o_data,
    output msp_pkg::t_q_status          o_status
);

    localparam int PB = msp_pkg::Q_PTR_BITS;
    localparam int LB = msp_pkg::Q_LEVEL_BITS;

    msp_pkg::t_out_item r_mem [msp_pkg::Q_DEPTH];
    logic [PB-1:0] r_wr, n_wr;
    logic [PB-1:0] r_rd, n_rd;
    logic [LB-1:0] r_level, n_level;

    always_comb begin
        n_wr    = r_wr + PB'(i_push.count);
        n_rd    = r_rd + PB'(i_pop);
        n_level = r_level + LB'(i_push.count) - LB'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + PB'(1)] <= i_push.rec1;
        end
    end

    assign o_data          = r_mem[r_rd];
    assign o_status.valid  = (r_level != '0);
    assign o_status.room   = (r_level <= LB'(msp_pkg::Q_DEPTH - 2));
    assign o_status.level  = r_level;

endmodule
`default_nettype wire

### design/msp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msp_back
// Output register: drains the record queue onto the result channel.
// ----------------------------------------------------------------------------
module msp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire msp_pkg::t_q_status i_q_status,
    input  wire msp_pkg::t_out_item i_q_data,
    input  wire logic               i_stall,
    output logic                    o_pop,
    output logic                    o_valid,
    output msp_pkg::t_out_item      o_item
);

    logic               r_valid, n_valid;
    msp_pkg::t_out_item r_item, n_item;

    always_comb begin
        o_pop   = i_q_status.valid && (!r_valid || !i_stall);
        n_valid = r_valid;
        n_item  = r_item;
        if (o_pop) begin
            n_valid = 1'b1;
            n_item  = i_q_data;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

### design/mgt_section_payload_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mgt_section_payload_parser
// Master guide table section payload parser, one payload byte per beat.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle and turns it into header, table entry,
// descriptor, data byte, done and error records. The parser writes zero, one
// or two records per byte into a four-record queue; it takes a byte whenever
// at least two queue slots are free, so with the result side ready it runs at
// one byte per cycle. The output register drains one record per cycle when
// not stalled; when a byte yields two records (header or entry followed by
// an error, a descriptor or last data byte closing a loop followed by done
// or an error), the second waits in the queue. A byte's first record passes
// through the queue, then the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module mgt_section_payload_parser #(
    parameter int LENGTH_BITS = 12
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire msp_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output msp_pkg::t_out_item      o_item
);

    msp_pkg::t_push     push;
    msp_pkg::t_q_status q_status;
    msp_pkg::t_out_item q_data;
    logic               pop;
    logic               in_accept;

    assign o_stall   = !q_status.room;
    assign in_accept = i_valid && !o_stall;

    msp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_item),
        .o_push   (push)
    );

    msp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    msp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

`ifndef SYNTHESIS
    a_no_push_without_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> (push.count == 2'd0))
        else $error("record pushed without an input beat");

    a_push_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd3)
        else $error("more than two records from one beat");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= msp_pkg::Q_LEVEL_BITS'(msp_pkg::Q_DEPTH))
        else $error("record queue overflow");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.valid && !o_valid) |=> o_valid)
        else $error("queued record not moved to output");
`endif

endmodule
`default_nettype wire
